### hdl/dqs_pkg.sv
// ---------------------------------------------------------------------------
// dqs_pkg: shared types and codes for the searchable deque
// Request and response transfer types, operation and status codes, defaults.
// ---------------------------------------------------------------------------
package dqs_pkg;

   localparam int DEPTH_DEFAULT = 64;
   localparam int DATA_W        = 32;
   localparam int POS_W         = 7;

   localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [2:0] OP_POP_FRONT  = 3'd2;
   localparam logic [2:0] OP_POP_BACK   = 3'd3;
   localparam logic [2:0] OP_SEARCH     = 3'd4;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_EMPTY     = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;
   localparam logic [1:0] ST_NOT_FOUND = 2'd3;

   typedef struct packed {
      logic [2:0]               operation;
      logic signed [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]               status;
      logic signed [DATA_W-1:0] removed_value;
      logic [POS_W-1:0]         position;
   } rsp_type;

endpackage

### hdl/dqs_ram.sv
// ---------------------------------------------------------------------------
// dqs_ram: ring storage
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module dqs_ram #(
   parameter int DEPTH = dqs_pkg::DEPTH_DEFAULT,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [AW-1:0]             wr_addr,
   input  logic [dqs_pkg::DATA_W-1:0] wr_data,
   input  logic [AW-1:0]             rd_addr,
   output logic [dqs_pkg::DATA_W-1:0] rd_data
);

   logic [dqs_pkg::DATA_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

### hdl/dqs_ring.sv
// ---------------------------------------------------------------------------
// dqs_ring: shared ring index unit
// Adds or subtracts an offset to a ring index, wrapping modulo DEPTH.
// ---------------------------------------------------------------------------
module dqs_ring #(
   parameter int DEPTH = dqs_pkg::DEPTH_DEFAULT,
   parameter int AW    = $clog2(DEPTH),
   parameter int CW    = $clog2(DEPTH + 1)
) (
   input  logic [AW-1:0] base,
   input  logic [CW-1:0] offset,
   input  logic          dec,
   output logic [AW-1:0] idx
);

   logic [CW:0] addend;
   logic [CW:0] sum;
   logic [CW:0] wrapped;

   always_comb begin
      addend  = dec ? ((CW+1)'(DEPTH) - {1'b0, offset}) : {1'b0, offset};
      sum     = (CW+1)'(base) + addend;
      wrapped = (sum >= (CW+1)'(DEPTH)) ? (sum - (CW+1)'(DEPTH)) : sum;
      idx     = wrapped[AW-1:0];
   end

endmodule

### hdl/deque_with_search.sv
// ---------------------------------------------------------------------------
// deque_with_search: bounded double-ended queue with linear search
// Ring of DEPTH signed words; push/pop at either end, search from the front.
//
//  channel  ports                          transfer when
//  request  start, busy, req_data          start && !busy
//  response rsp_strobe, rsp_data           rsp_strobe (one cycle, no stall)
//
//  Push and unused codes: busy only in S_EXEC; the result is registered from it.
//  Pop: busy in S_EXEC, then S_POP for the registered memory read; S_EXEC only
//  when empty. Search: busy in S_EXEC, then in S_SCAN up to the match position,
//  or the occupancy when no match; one memory read and one compare per cycle.
//  Reset clears the front index and occupancy; the store is not cleared.
//  The receiver cannot stall; results are never held back.
// ---------------------------------------------------------------------------
module deque_with_search #(
   parameter int DEPTH = dqs_pkg::DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  dqs_pkg::req_type req_data,
   output logic             rsp_strobe,
   output dqs_pkg::rsp_type rsp_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_POP,
      S_SCAN
   } state_type;

   state_type                  state_ff, state_in;
   logic [2:0]                 op_ff, op_in;
   logic [dqs_pkg::DATA_W-1:0] value_ff, value_in;
   logic [AW-1:0]              front_ff, front_in;
   logic [CW-1:0]              occ_ff, occ_in;
   logic [AW-1:0]              scan_addr_ff, scan_addr_in;
   logic [CW-1:0]              cnt_ff, cnt_in;
   dqs_pkg::rsp_type           rsp_ff, rsp_in;
   logic                       rsp_strobe_ff, rsp_strobe_in;

   logic                       wr_en;
   logic [AW-1:0]              wr_addr;
   logic [AW-1:0]              rd_addr;
   logic [dqs_pkg::DATA_W-1:0] rd_data;

   logic [AW-1:0]              ring_base;
   logic [CW-1:0]              ring_offset;
   logic                       ring_dec;
   logic [AW-1:0]              ring_idx;

   logic                       is_full;
   logic                       is_empty;
   logic [CW+7:0]              pos_ext;
   logic [CW-1:0]              cnt_next;

   dqs_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (value_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   dqs_ring #(.DEPTH(DEPTH), .AW(AW), .CW(CW)) u_ring (
      .base   (ring_base),
      .offset (ring_offset),
      .dec    (ring_dec),
      .idx    (ring_idx)
   );

   assign is_full    = (occ_ff == CW'(DEPTH));
   assign is_empty   = (occ_ff == '0);
   assign cnt_next   = cnt_ff + CW'(1);
   assign pos_ext    = {8'd0, cnt_ff} + (CW+8)'(1);
   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   // shared ring unit operand select
   always_comb begin
      ring_base   = front_ff;
      ring_offset = occ_ff;
      ring_dec    = 1'b0;
      if (state_ff == S_SCAN) begin
         ring_base   = scan_addr_ff;
         ring_offset = CW'(1);
      end else begin
         case (op_ff)
            dqs_pkg::OP_PUSH_FRONT: begin
               ring_offset = CW'(1);
               ring_dec    = 1'b1;
            end
            dqs_pkg::OP_POP_BACK: begin
               ring_offset = occ_ff - CW'(1);
            end
            dqs_pkg::OP_SEARCH: begin
               ring_offset = CW'(1);
            end
            default: begin
               ring_offset = occ_ff;
            end
         endcase
      end
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      value_in      = value_ff;
      front_in      = front_ff;
      occ_in        = occ_ff;
      scan_addr_in  = scan_addr_ff;
      cnt_in        = cnt_ff;
      rsp_in        = rsp_ff;
      rsp_strobe_in = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = ring_idx;
      rd_addr       = front_ff;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in    = req_data.operation;
               value_in = req_data.value;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            rsp_in.status        = dqs_pkg::ST_OK;
            rsp_in.removed_value = '0;
            rsp_in.position      = '0;
            state_in             = S_IDLE;
            rsp_strobe_in        = 1'b1;
            case (op_ff)
               dqs_pkg::OP_PUSH_FRONT, dqs_pkg::OP_PUSH_BACK: begin
                  if (is_full) begin
                     rsp_in.status = dqs_pkg::ST_FULL;
                  end else begin
                     wr_en  = 1'b1;
                     occ_in = occ_ff + CW'(1);
                     if (op_ff == dqs_pkg::OP_PUSH_FRONT) begin
                        front_in = ring_idx;
                     end
                  end
               end
               dqs_pkg::OP_POP_FRONT, dqs_pkg::OP_POP_BACK: begin
                  if (is_empty) begin
                     rsp_in.status = dqs_pkg::ST_EMPTY;
                  end else begin
                     rsp_strobe_in = 1'b0;
                     state_in      = S_POP;
                     occ_in        = occ_ff - CW'(1);
                     if (op_ff == dqs_pkg::OP_POP_BACK) begin
                        rd_addr = ring_idx;
                     end else begin
                        rd_addr  = front_ff;
                        front_in = (front_ff == AW'(DEPTH - 1)) ? '0
                                                                 : front_ff + AW'(1);
                     end
                  end
               end
               dqs_pkg::OP_SEARCH: begin
                  if (is_empty) begin
                     rsp_in.status = dqs_pkg::ST_EMPTY;
                  end else begin
                     rsp_strobe_in = 1'b0;
                     state_in      = S_SCAN;
                     rd_addr       = front_ff;
                     scan_addr_in  = ring_idx;
                     cnt_in        = '0;
                  end
               end
               default: begin
               end
            endcase
         end
         S_POP: begin
            rsp_in.status        = dqs_pkg::ST_OK;
            rsp_in.removed_value = rd_data;
            rsp_in.position      = '0;
            rsp_strobe_in        = 1'b1;
            state_in             = S_IDLE;
         end
         S_SCAN: begin
            rd_addr              = scan_addr_ff;
            scan_addr_in         = ring_idx;
            cnt_in               = cnt_next;
            rsp_in.removed_value = '0;
            rsp_in.position      = '0;
            if (rd_data == value_ff) begin
               rsp_in.status   = dqs_pkg::ST_OK;
               rsp_in.position = pos_ext[dqs_pkg::POS_W-1:0];
               rsp_strobe_in   = 1'b1;
               state_in        = S_IDLE;
            end else if (cnt_next == occ_ff) begin
               rsp_in.status = dqs_pkg::ST_NOT_FOUND;
               rsp_strobe_in = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         front_ff      <= '0;
         occ_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         front_ff      <= front_in;
         occ_ff        <= occ_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      op_ff        <= op_in;
      value_ff     <= value_in;
      scan_addr_ff <= scan_addr_in;
      cnt_ff       <= cnt_in;
      rsp_ff       <= rsp_in;
   end

endmodule

### sim/tb_deque_with_search.sv
// ---------------------------------------------------------------------------
// tb_deque_with_search: self-checking bench for the searchable deque
// Drives pushes, pops, searches and spare codes through the start/busy
// command port, mirrors the ring in a local predictor at each accepted
// transfer and checks every response strobe against the oldest prediction.
// Phases vary the sender idle rate; each phase drains before the next starts.
// ---------------------------------------------------------------------------
module tb_deque_with_search;

   localparam int DEPTH    = dqs_pkg::DEPTH_DEFAULT;
   localparam int IDX_W    = $clog2(DEPTH);
   localparam int ITEMS    = 2000;
   localparam int RECENT   = 16;
   localparam int WATCHDOG = 4000;
   localparam int TAIL     = DEPTH + 8;

   localparam logic [2:0] OP_SPARE_FIRST = dqs_pkg::OP_SEARCH + 3'd1;
   localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

   localparam logic signed [dqs_pkg::DATA_W-1:0] VAL_MAX =
      {1'b0, {(dqs_pkg::DATA_W-1){1'b1}}};
   localparam logic signed [dqs_pkg::DATA_W-1:0] VAL_MIN =
      {1'b1, {(dqs_pkg::DATA_W-1){1'b0}}};

   logic             clock    = 1'b0;
   logic             reset    = 1'b1;
   logic             start    = 1'b0;
   dqs_pkg::req_type req_data = '0;
   logic             busy;
   logic             rsp_strobe;
   dqs_pkg::rsp_type rsp_data;

   dqs_pkg::req_type pending_items [$];
   dqs_pkg::rsp_type expected_rsp [$];
   int      n_queued   = 0;
   int      n_accepted = 0;
   int      n_errors   = 0;
   int      quiet      = 0;
   int      idle_pct   = 0;
   logic    took       = 1'b0;

   // predictor state
   logic signed [dqs_pkg::DATA_W-1:0] ring [DEPTH];
   logic [IDX_W-1:0]                  head = '0;
   int                                fill = 0;

   logic signed [dqs_pkg::DATA_W-1:0] recent [RECENT] = '{default: '0};

   deque_with_search #(.DEPTH(DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic dqs_pkg::rsp_type deque_apply(dqs_pkg::req_type r);
      dqs_pkg::rsp_type o;
      logic             hit;
      o = '0;
      hit = 1'b0;
      case (r.operation)
         dqs_pkg::OP_PUSH_FRONT, dqs_pkg::OP_PUSH_BACK: begin
            if (fill == DEPTH) begin
               o.status = dqs_pkg::ST_FULL;
            end else if (r.operation == dqs_pkg::OP_PUSH_FRONT) begin
               head = head - 1'b1;
               ring[head] = r.value;
               fill++;
            end else begin
               ring[head + IDX_W'(fill)] = r.value;
               fill++;
            end
         end
         dqs_pkg::OP_POP_FRONT: begin
            if (fill == 0) begin
               o.status = dqs_pkg::ST_EMPTY;
            end else begin
               o.removed_value = ring[head];
               head = head + 1'b1;
               fill--;
            end
         end
         dqs_pkg::OP_POP_BACK: begin
            if (fill == 0) begin
               o.status = dqs_pkg::ST_EMPTY;
            end else begin
               o.removed_value = ring[head + IDX_W'(fill - 1)];
               fill--;
            end
         end
         dqs_pkg::OP_SEARCH: begin
            if (fill == 0) begin
               o.status = dqs_pkg::ST_EMPTY;
            end else begin
               o.status = dqs_pkg::ST_NOT_FOUND;
               for (int k = 0; k < fill; k++) begin
                  if (!hit && ring[head + IDX_W'(k)] == r.value) begin
                     hit = 1'b1;
                     o.status = dqs_pkg::ST_OK;
                     o.position = dqs_pkg::POS_W'(k + 1);
                  end
               end
            end
         end
         default: ;
      endcase
      return o;
   endfunction

   task automatic report(input string what, input dqs_pkg::rsp_type want,
                         input dqs_pkg::rsp_type got);
      n_errors++;
      if (n_errors <= 10)
         $display("%0t %s: expected status %0d removed %0d position %0d, got %0d %0d %0d",
                  $realtime, what, want.status, want.removed_value, want.position,
                  got.status, got.removed_value, got.position);
   endtask

   // driver: one item per transfer, random gaps
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || took) begin
         if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct) begin
            start    <= 1'b1;
            req_data <= pending_items.pop_front();
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor, predictor and watchdog
   always @(posedge clock) begin
      dqs_pkg::rsp_type want;
      if (reset) begin
         took  = 1'b0;
         quiet = 0;
      end else begin
         took = start && !busy;
         if (rsp_strobe) begin
            if (expected_rsp.size() == 0) begin
               report("unexpected response", '0, rsp_data);
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_data.status !== want.status ||
                   rsp_data.removed_value !== want.removed_value ||
                   rsp_data.position !== want.position)
                  report("response mismatch", want, rsp_data);
            end
         end
         if (took) begin
            expected_rsp.push_back(deque_apply(req_data));
            n_accepted++;
         end
         quiet = (took || rsp_strobe) ? 0 : quiet + 1;
         if (quiet >= WATCHDOG) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   task automatic queue_item(input logic [2:0] op,
                             input logic signed [dqs_pkg::DATA_W-1:0] val);
      pending_items.push_back(dqs_pkg::req_type'{operation: op, value: val});
      n_queued++;
   endtask

   function automatic logic signed [dqs_pkg::DATA_W-1:0] pick_value();
      logic signed [dqs_pkg::DATA_W-1:0] v;
      case ($urandom_range(3))
         0: v = $urandom;
         1: begin
            case ($urandom_range(3))
               0: v = VAL_MAX;
               1: v = VAL_MIN;
               2: v = '0;
               default: v = '1;
            endcase
         end
         default: v = $urandom_range(12) - 6;
      endcase
      return v;
   endfunction

   // bursts biased to fill, drain or mix so that full and empty both occur
   task automatic queue_random(input int count);
      int left, seg, mode, roll, pw, qw;
      logic [2:0] op;
      logic signed [dqs_pkg::DATA_W-1:0] val;
      left = count;
      while (left > 0) begin
         mode = $urandom_range(2);
         seg  = $urandom_range(160, 40);
         pw   = (mode == 0) ? 55 : (mode == 1) ? 15 : 30;
         qw   = (mode == 0) ? 15 : (mode == 1) ? 55 : 30;
         for (int i = 0; i < seg && left > 0; i++) begin
            roll = $urandom_range(99);
            if (roll < pw)
               op = $urandom_range(1) ? dqs_pkg::OP_PUSH_BACK : dqs_pkg::OP_PUSH_FRONT;
            else if (roll < pw + qw)
               op = $urandom_range(1) ? dqs_pkg::OP_POP_BACK : dqs_pkg::OP_POP_FRONT;
            else if (roll < pw + qw + 5)
               op = 3'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
            else
               op = dqs_pkg::OP_SEARCH;
            if (op == dqs_pkg::OP_SEARCH && $urandom_range(99) < 60)
               val = recent[$urandom_range(RECENT - 1)];
            else
               val = pick_value();
            if (op == dqs_pkg::OP_PUSH_FRONT || op == dqs_pkg::OP_PUSH_BACK)
               recent[$urandom_range(RECENT - 1)] = val;
            queue_item(op, val);
            left--;
         end
      end
   endtask

   task automatic settle();
      do @(negedge clock);
      while (n_accepted != n_queued || expected_rsp.size() != 0);
   endtask

   initial begin
      int phase_idle [4];
      phase_idle = '{0, 79, 23, 0};
      repeat (9) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      @(posedge clock);

      // empty cases, both extremes, search hitting first and last entries
      queue_item(dqs_pkg::OP_SEARCH, '0);
      queue_item(dqs_pkg::OP_POP_FRONT, $urandom);
      queue_item(dqs_pkg::OP_POP_BACK, $urandom);
      queue_item(dqs_pkg::OP_PUSH_FRONT, VAL_MAX);
      queue_item(dqs_pkg::OP_PUSH_BACK, VAL_MIN);
      queue_item(dqs_pkg::OP_PUSH_FRONT, '0);
      queue_item(dqs_pkg::OP_PUSH_BACK, '1);
      queue_item(dqs_pkg::OP_SEARCH, '1);
      queue_item(dqs_pkg::OP_SEARCH, '0);
      queue_item(dqs_pkg::OP_SEARCH, VAL_MAX);
      queue_item(dqs_pkg::OP_SEARCH, VAL_MIN);
      queue_item(dqs_pkg::OP_SEARCH, 32'sd12345);
      for (int c = OP_SPARE_FIRST; c <= OP_SPARE_LAST; c++)
         queue_item(3'(c), $urandom);
      queue_item(dqs_pkg::OP_POP_BACK, $urandom);
      queue_item(dqs_pkg::OP_POP_FRONT, $urandom);
      queue_item(dqs_pkg::OP_SEARCH, '1);
      queue_item(dqs_pkg::OP_POP_FRONT, $urandom);
      queue_item(dqs_pkg::OP_POP_BACK, $urandom);
      queue_item(dqs_pkg::OP_POP_BACK, $urandom);
      queue_item(dqs_pkg::OP_SEARCH, VAL_MAX);
      settle();

      foreach (phase_idle[p]) begin
         @(posedge clock);
         idle_pct = phase_idle[p];
         queue_random(ITEMS / 4);
         settle();
      end

      repeat (TAIL) @(posedge clock);
      if (n_errors == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
